FILE: rtl/tor_pkg.sv
// Types, codes and constants shared by the transient onset/release detector.
package tor_pkg;

    localparam int unsigned MS_TO_US  = 1000;
    // 65535 ms in microseconds needs 26 bits
    localparam int unsigned US_W      = 26;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned LEN_W     = 23;

    // floor(d / 1000) = floor((d >> 3) * LEN_RECIP >> LEN_SHIFT), exact for 29-bit d >> 3
    localparam int unsigned LEN_PRE    = 3;
    localparam int unsigned LEN_X_W    = 32 - LEN_PRE;
    localparam int unsigned LEN_RCP_W  = 30;
    localparam logic [LEN_RCP_W-1:0] LEN_RECIP = 30'd549755814;
    localparam int unsigned LEN_SHIFT  = 36;
    localparam int unsigned LEN_PROD_W = LEN_X_W + LEN_RCP_W;

    typedef enum logic [1:0] {
        ONSET_NONE     = 2'd0,
        ONSET_BELOW    = 2'd1,
        ONSET_ACTIVE   = 2'd2,
        ONSET_COOLDOWN = 2'd3
    } t_onset_reason;

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED  = 2'd0,
        VERDICT_TOO_SHORT = 2'd1,
        VERDICT_TOO_LONG  = 2'd2,
        VERDICT_WEAK      = 2'd3
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_LEVEL    = 3'd0,
        CFG_RELEASE_LEVEL   = 3'd1,
        CFG_COOLDOWN_MS     = 3'd2,
        CFG_RELEASE_HOLD_MS = 3'd3,
        CFG_MIN_LENGTH_MS   = 3'd4,
        CFG_MAX_LENGTH_MS   = 3'd5,
        CFG_MIN_PEAK_LEVEL  = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic          onset_fired;
        t_onset_reason onset_reject_reason;
        logic          peak_is_open;
        logic          closed;
        logic          accepted;
        t_verdict      close_reason;
        logic [15:0]   peak_value;
        logic [31:0]   start_stamp_us;
        logic [31:0]   max_stamp_us;
        logic [31:0]   onset_blocked_total;
        logic [31:0]   reject_total;
    } t_result;

    function automatic logic [US_W-1:0] ms_to_us(input logic [CFG_W-1:0] v);
        return US_W'(v) * US_W'(MS_TO_US);
    endfunction

endpackage

FILE: rtl/transient_onset_release_detector_top.sv
// Transient onset/release detector: input register, state update, duration scaling, output.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+--------------------------------------------
//  sample   | i_valid   | o_stall   | i_time_us, i_magnitude
//  result   | o_valid   | i_stall   | o_onset_fired ... o_reject_total
//  config   | i_cfg_wr_en (no stall) | i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the result port is not stalled; a sample is registered
// through the input register, stage 1 and stage 2, and its result is offered from stage 2.
// The detector state updates in the single cycle the beat leaves the input register; the
// duration-to-ms multiply has a stage of its own.
// Synchronous active-low reset clears state, counters, stage valids and config (max length to 65535 ms).
// A stall at the result port backs up through the three stages before o_stall rises.
module transient_onset_release_detector_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_time_us,
    input  logic [15:0] i_magnitude,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_onset_fired,
    output logic [1:0]  o_onset_reject_reason,
    output logic        o_peak_is_open,
    output logic        o_closed,
    output logic        o_accepted,
    output logic [1:0]  o_close_reason,
    output logic [15:0] o_peak_value,
    output logic [22:0] o_length_ms,
    output logic [31:0] o_start_stamp_us,
    output logic [31:0] o_max_stamp_us,
    output logic [31:0] o_onset_blocked_total,
    output logic [31:0] o_reject_total
);

    // configuration, time values held in microseconds
    logic [15:0]             r_attack_level;
    logic [15:0]             r_release_level;
    logic [tor_pkg::US_W-1:0] r_cooldown_us;
    logic [tor_pkg::US_W-1:0] r_hold_us;
    logic [tor_pkg::US_W-1:0] r_min_len_us;
    logic [tor_pkg::US_W-1:0] r_max_len_us;
    logic [15:0]             r_min_peak_level;

    // detector state
    logic              r_open;
    logic [31:0]       r_open_time;
    logic [31:0]       r_max_time;
    logic [15:0]       r_max_level;
    logic [31:0]       r_last_onset;
    logic              r_pending;
    logic [31:0]       r_release_time;
    logic [31:0]       r_blocked;
    logic [31:0]       r_rejected;
    tor_pkg::t_verdict r_verdict;

    // stage registers
    logic             r0_valid;
    logic [31:0]      r0_time;
    logic [15:0]      r0_mag;
    logic             r1_valid;
    tor_pkg::t_result r1_res;
    logic [31:0]      r1_dur;
    logic             r2_valid;
    tor_pkg::t_result r2_res;
    logic [tor_pkg::LEN_PROD_W-1:0] r2_prod;

    logic en0, en1, en2, adv0;

    assign en2  = !r2_valid || !i_stall;
    assign en1  = !r1_valid || en2;
    assign en0  = !r0_valid || en1;
    assign adv0 = r0_valid && en1;
    assign o_stall = !en0;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_level   <= '0;
            r_release_level  <= '0;
            r_cooldown_us    <= '0;
            r_hold_us        <= '0;
            r_min_len_us     <= '0;
            r_max_len_us     <= tor_pkg::ms_to_us(16'hFFFF);
            r_min_peak_level <= '0;
        end else if (i_cfg_wr_en) begin
            case (tor_pkg::t_cfg_index'(i_cfg_index))
                tor_pkg::CFG_ATTACK_LEVEL:    r_attack_level   <= i_cfg_data;
                tor_pkg::CFG_RELEASE_LEVEL:   r_release_level  <= i_cfg_data;
                tor_pkg::CFG_COOLDOWN_MS:     r_cooldown_us    <= tor_pkg::ms_to_us(i_cfg_data);
                tor_pkg::CFG_RELEASE_HOLD_MS: r_hold_us        <= tor_pkg::ms_to_us(i_cfg_data);
                tor_pkg::CFG_MIN_LENGTH_MS:   r_min_len_us     <= tor_pkg::ms_to_us(i_cfg_data);
                tor_pkg::CFG_MAX_LENGTH_MS:   r_max_len_us     <= tor_pkg::ms_to_us(i_cfg_data);
                tor_pkg::CFG_MIN_PEAK_LEVEL:  r_min_peak_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en0) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_valid) begin
            r0_time <= i_time_us;
            r0_mag  <= i_magnitude;
        end
    end

    // ---------------- state update ----------------
    logic              above_attack, above_release, cool_done, onset;
    logic              hold_done, dur_ok, str_ok;
    logic              n_open, n_pending;
    logic [31:0]       n_open_time, n_max_time, n_last_onset, n_release_time;
    logic [15:0]       n_max_level;
    logic [31:0]       n_blocked, n_rejected, n_dur;
    tor_pkg::t_verdict n_verdict;
    tor_pkg::t_result  n_res;
    logic [31:0]       dur;

    always_comb begin
        above_attack  = r0_mag > r_attack_level;
        above_release = r0_mag > r_release_level;
        cool_done     = (r0_time - r_last_onset) >= 32'(r_cooldown_us);
        onset         = above_attack && !r_open && cool_done;

        n_open         = r_open;
        n_open_time    = r_open_time;
        n_max_time     = r_max_time;
        n_max_level    = r_max_level;
        n_last_onset   = r_last_onset;
        n_pending      = r_pending;
        n_release_time = r_release_time;
        n_blocked      = r_blocked;
        n_rejected     = r_rejected;
        n_verdict      = r_verdict;
        n_res          = '0;
        n_dur          = '0;

        if (onset) begin
            n_open       = 1'b1;
            n_open_time  = r0_time;
            n_max_time   = r0_time;
            n_max_level  = r0_mag;
            n_last_onset = r0_time;
            n_res.onset_reject_reason = tor_pkg::ONSET_NONE;
        end else if (!above_attack) begin
            n_res.onset_reject_reason = tor_pkg::ONSET_BELOW;
        end else if (r_open) begin
            n_res.onset_reject_reason = tor_pkg::ONSET_ACTIVE;
            n_blocked = r_blocked + 32'd1;
        end else begin
            n_res.onset_reject_reason = tor_pkg::ONSET_COOLDOWN;
            n_blocked = r_blocked + 32'd1;
        end
        n_res.onset_fired = onset;

        if (n_open) begin
            if (r0_mag > n_max_level) begin
                n_max_level = r0_mag;
                n_max_time  = r0_time;
            end
            if (!above_release) begin
                if (!n_pending) begin
                    n_pending      = 1'b1;
                    n_release_time = r0_time;
                end
            end else begin
                n_pending      = 1'b0;
                n_release_time = '0;
            end
            n_res.peak_value     = n_max_level;
            n_res.start_stamp_us = n_open_time;
            n_res.max_stamp_us   = n_max_time;
        end

        hold_done = (r0_time - n_release_time) >= 32'(r_hold_us);
        dur       = n_release_time - n_open_time;
        // inverted window falls out of the order: short first, anything else out of range is long
        dur_ok    = (dur >= 32'(r_min_len_us)) && (dur <= 32'(r_max_len_us));
        str_ok    = n_max_level >= r_min_peak_level;

        if (n_open && n_pending && hold_done) begin
            n_res.closed = 1'b1;
            n_dur        = dur;
            if (dur_ok && str_ok) begin
                n_res.accepted = 1'b1;
                n_verdict      = tor_pkg::VERDICT_ACCEPTED;
            end else begin
                n_rejected = r_rejected + 32'd1;
                if (!dur_ok) begin
                    n_verdict = (dur < 32'(r_min_len_us)) ? tor_pkg::VERDICT_TOO_SHORT
                                                          : tor_pkg::VERDICT_TOO_LONG;
                end else begin
                    n_verdict = tor_pkg::VERDICT_WEAK;
                end
            end
            n_open         = 1'b0;
            n_open_time    = '0;
            n_max_time     = '0;
            n_max_level    = '0;
            n_pending      = 1'b0;
            n_release_time = '0;
        end

        n_res.peak_is_open        = n_open;
        n_res.close_reason        = n_verdict;
        n_res.onset_blocked_total = n_blocked;
        n_res.reject_total        = n_rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open         <= 1'b0;
            r_open_time    <= '0;
            r_max_time     <= '0;
            r_max_level    <= '0;
            r_last_onset   <= '0;
            r_pending      <= 1'b0;
            r_release_time <= '0;
            r_blocked      <= '0;
            r_rejected     <= '0;
            r_verdict      <= tor_pkg::VERDICT_ACCEPTED;
        end else if (adv0) begin
            r_open         <= n_open;
            r_open_time    <= n_open_time;
            r_max_time     <= n_max_time;
            r_max_level    <= n_max_level;
            r_last_onset   <= n_last_onset;
            r_pending      <= n_pending;
            r_release_time <= n_release_time;
            r_blocked      <= n_blocked;
            r_rejected     <= n_rejected;
            r_verdict      <= n_verdict;
        end
    end

    // ---------------- stage 1: result fields and raw duration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r1_res <= n_res;
            r1_dur <= n_dur;
        end
    end

    // ---------------- stage 2: duration in ms by reciprocal multiply ----------------
    logic [tor_pkg::LEN_PROD_W-1:0] n_prod;

    assign n_prod = tor_pkg::LEN_PROD_W'(r1_dur[31:tor_pkg::LEN_PRE])
                  * tor_pkg::LEN_PROD_W'(tor_pkg::LEN_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_valid) begin
            r2_res  <= r1_res;
            r2_prod <= n_prod;
        end
    end

    // ---------------- outputs ----------------
    assign o_valid               = r2_valid;
    assign o_onset_fired         = r2_res.onset_fired;
    assign o_onset_reject_reason = r2_res.onset_reject_reason;
    assign o_peak_is_open        = r2_res.peak_is_open;
    assign o_closed              = r2_res.closed;
    assign o_accepted            = r2_res.accepted;
    assign o_close_reason        = r2_res.close_reason;
    assign o_peak_value          = r2_res.peak_value;
    assign o_length_ms           = r2_prod[tor_pkg::LEN_SHIFT +: tor_pkg::LEN_W];
    assign o_start_stamp_us      = r2_res.start_stamp_us;
    assign o_max_stamp_us        = r2_res.max_stamp_us;
    assign o_onset_blocked_total = r2_res.onset_blocked_total;
    assign o_reject_total        = r2_res.reject_total;

endmodule

FILE: rtl/tor_checker.sv
// Port-level checks for the transient onset/release detector, bound to the top level.
module tor_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_onset_fired,
    input logic [1:0]  o_onset_reject_reason,
    input logic        o_peak_is_open,
    input logic        o_closed,
    input logic        o_accepted,
    input logic [1:0]  o_close_reason,
    input logic [22:0] o_length_ms,
    input logic [31:0] o_reject_total
);

    // a fired onset carries no reject reason
    a_onset_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_onset_fired |-> o_onset_reject_reason == tor_pkg::ONSET_NONE)
        else $error("onset fired with a reject reason");

    // an accepted beat must be a close with an accepted verdict
    a_accept_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_closed && o_close_reason == tor_pkg::VERDICT_ACCEPTED)
        else $error("accepted without a clean close");

    // a closing beat leaves no peak open
    a_close_shut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_closed |-> !o_peak_is_open)
        else $error("peak still open after close");

    // duration only reported on a close
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_closed |-> o_length_ms == '0)
        else $error("length reported without close");

    // held result beat stays put under stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reject_total) && $stable(o_length_ms))
        else $error("result beat changed under stall");

endmodule

bind transient_onset_release_detector_top tor_checker u_tor_checker (.*);
